// ===== sv/rlm_pkg.sv =====
// Shared types and constants for the RMS window level meter.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none

package rlm_pkg;

   // Widths of the sample word and of the result word.
   localparam int SAMPLE_W = 16;
   localparam int LEVEL_W  = 8;

   // A full-scale square is 2^30 and needs 31 bits.
   localparam int SQ_LOG = 2 * (SAMPLE_W - 1);
   localparam int SQ_W   = SQ_LOG + 1;

   // Window queue between the accumulator and the level unit.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Occupancy of the window queue as seen by both of its neighbors.
   typedef struct packed {
      logic                   empty;
      logic [QUEUE_CNT_W-1:0] used;
   } rlm_queue_status_type;

endpackage

`default_nettype wire

// ===== sv/rms_window_led_level_meter_unit.sv =====
// RMS window LED level meter, top level.
// Instantiates rlm_front, rlm_queue and rlm_back; depends on rlm_pkg.
//
// Usage: the req channel carries one signed 16-bit PCM sample per word with a
// last flag that closes the measurement window. A window also closes on its
// MAX_WINDOW-th word. For each closed window the rsp channel carries one 8-bit
// level, the largest L with L^4 * 2^30 * count <= 255^4 * sum of squares.
// Both channels use valid/stall; a word moves when valid is high and stall low.
// Throughput: one sample word per cycle within a window while req_stall is low.
// The level unit takes one closed window at a time: a multiply over the ND
// 24-bit digits of the square sum, ND = ceil((30 + CW) / 24) and CW =
// clog2(MAX_WINDOW + 1), then a restoring divide and a fourth-root search. A
// four-entry window queue absorbs bursts of short windows; req_stall rises when
// it cannot take another one.
// Reset (synchronous) empties the window, the queue and the result register.
// While rsp_stall is high the level is held; the level unit finishes its
// next window and then waits, and the queue keeps filling until it is full.
`default_nettype none

module rms_window_led_level_meter_unit #(
   parameter int MAX_WINDOW = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [rlm_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                                req_last,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [rlm_pkg::LEVEL_W-1:0]         rsp_level
);

   localparam int CW = $clog2(MAX_WINDOW + 1);
   localparam int SW = rlm_pkg::SQ_LOG + CW;

   rlm_pkg::rlm_queue_status_type q_status;
   logic                          q_push;
   logic [SW+CW-1:0]              q_push_data;
   logic                          q_pop;
   logic [SW+CW-1:0]              q_pop_data;

   // Accumulator for the open window.
   rlm_front #(
      .MAX_WINDOW (MAX_WINDOW),
      .CW         (CW),
      .SW         (SW)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_sample (req_sample),
      .req_last   (req_last),
      .q_status   (q_status),
      .q_push     (q_push),
      .q_data     (q_push_data)
   );

   // Closed windows waiting for the level unit.
   rlm_queue #(
      .WIDTH (SW + CW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .status    (q_status)
   );

   // Level unit and result register.
   rlm_back #(
      .MAX_WINDOW (MAX_WINDOW),
      .CW         (CW),
      .SW         (SW)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .q_data    (q_pop_data),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_level (rsp_level)
   );

endmodule

`default_nettype wire

// ===== sv/rlm_queue.sv =====
// Short queue of closed windows (square sum and sample count).
// Depends on rlm_pkg for depth, pointer widths and the status struct.
`default_nettype none

module rlm_queue #(
   parameter int WIDTH = 52
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   input  logic [WIDTH-1:0]                push_data,
   input  logic                            pop,
   output logic [WIDTH-1:0]                pop_data,
   output rlm_pkg::rlm_queue_status_type   status
);

   logic [WIDTH-1:0]                 mem_ff [rlm_pkg::QUEUE_DEPTH];
   logic [rlm_pkg::QUEUE_PTR_W-1:0]  wr_ptr_ff;
   logic [rlm_pkg::QUEUE_PTR_W-1:0]  rd_ptr_ff;
   logic [rlm_pkg::QUEUE_CNT_W-1:0]  used_ff;
   logic [rlm_pkg::QUEUE_CNT_W-1:0]  used_in;

   // Occupancy changes by one on a lone push or a lone pop.
   always_comb begin
      used_in = used_ff;
      if (push && !pop) begin
         used_in = used_ff + rlm_pkg::QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
         used_in = used_ff - rlm_pkg::QUEUE_CNT_W'(1);
      end
   end

   // Pointers and occupancy.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         used_ff   <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + rlm_pkg::QUEUE_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + rlm_pkg::QUEUE_PTR_W'(1);
         end
         used_ff <= used_in;
      end
   end

   // Entry storage; the oldest entry is always presented.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data     = mem_ff[rd_ptr_ff];
   assign status.used  = used_ff;
   assign status.empty = (used_ff == '0);

   // The neighbors never overrun or underrun the queue.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (pop || used_ff != rlm_pkg::QUEUE_CNT_W'(rlm_pkg::QUEUE_DEPTH)))
      else $error("window queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> (used_ff != '0))
      else $error("window queue read while empty");

endmodule

`default_nettype wire

// ===== sv/rlm_front.sv =====
// Front end: takes sample words, squares them and accumulates each window.
// Depends on rlm_pkg; pushes closed windows into rlm_queue.
`default_nettype none

module rlm_front #(
   parameter int MAX_WINDOW = 1024,
   parameter int CW         = $clog2(MAX_WINDOW + 1),
   parameter int SW         = rlm_pkg::SQ_LOG + CW
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [rlm_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                                req_last,
   input  rlm_pkg::rlm_queue_status_type       q_status,
   output logic                                q_push,
   output logic [SW+CW-1:0]                    q_data
);

   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_WINDOW);

   logic                          accept;
   logic [rlm_pkg::SAMPLE_W-1:0]  raw;
   logic [rlm_pkg::SAMPLE_W-1:0]  mag;
   logic [rlm_pkg::SQ_W-1:0]      sq_in;
   logic                          s1_valid_ff;
   logic                          s1_last_ff;
   logic [rlm_pkg::SQ_W-1:0]      s1_sq_ff;
   logic [SW-1:0]                 sum_ff;
   logic [SW-1:0]                 sum_in;
   logic [CW-1:0]                 cnt_ff;
   logic [CW-1:0]                 cnt_in;
   logic                          close;
   logic [rlm_pkg::QUEUE_CNT_W-1:0] pending;

   // Hold off new words unless the queue has room for the word in flight
   // and for the new one.
   assign pending   = q_status.used + rlm_pkg::QUEUE_CNT_W'(s1_valid_ff);
   assign req_stall = (pending >= rlm_pkg::QUEUE_CNT_W'(rlm_pkg::QUEUE_DEPTH));
   assign accept    = req_valid && !req_stall;

   // Magnitude and square of the sample; -32768 maps to 32768.
   assign raw   = req_sample;
   assign mag   = raw[rlm_pkg::SAMPLE_W-1] ? (rlm_pkg::SAMPLE_W'(0) - raw) : raw;
   assign sq_in = rlm_pkg::SQ_W'(mag) * rlm_pkg::SQ_W'(mag);

   // Square stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
      if (accept) begin
         s1_sq_ff   <= sq_in;
         s1_last_ff <= req_last;
      end
   end

   // Accumulate stage: a window closes on the marked word or when full.
   assign sum_in = sum_ff + SW'(s1_sq_ff);
   assign cnt_in = cnt_ff + CW'(1);
   assign close  = s1_last_ff || (cnt_in == MAX_CNT);
   assign q_push = s1_valid_ff && close;
   assign q_data = {sum_in, cnt_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         cnt_ff <= '0;
      end else if (s1_valid_ff) begin
         if (close) begin
            sum_ff <= '0;
            cnt_ff <= '0;
         end else begin
            sum_ff <= sum_in;
            cnt_ff <= cnt_in;
         end
      end
   end

   // An empty window has an empty sum.
   a_empty_window: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == '0) |-> (sum_ff == '0))
      else $error("square sum nonzero in an empty window");

endmodule

`default_nettype wire

// ===== sv/rlm_back.sv =====
// Back end: turns one closed window into a level by a partial-product multiply,
// a restoring divide and a bitwise fourth-root search. Depends on rlm_pkg.
`default_nettype none

module rlm_back #(
   parameter int MAX_WINDOW = 1024,
   parameter int CW         = $clog2(MAX_WINDOW + 1),
   parameter int SW         = rlm_pkg::SQ_LOG + CW
) (
   input  logic                               clock,
   input  logic                               reset,
   input  rlm_pkg::rlm_queue_status_type      q_status,
   input  logic [SW+CW-1:0]                   q_data,
   output logic                               q_pop,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [rlm_pkg::LEVEL_W-1:0]        rsp_level
);

   // 255^4: the full-scale square scaled to the level range.
   localparam int          K_W           = 32;
   localparam logic [K_W-1:0] FULL_SCALE_SQ = 32'd4228250625;
   localparam int DIG_W = 24;
   localparam int ND    = (SW + DIG_W - 1) / DIG_W;
   localparam int PW    = ND * DIG_W;
   localparam int PPW   = DIG_W + K_W;
   localparam int RW    = PW + K_W;
   localparam int NW    = RW - rlm_pkg::SQ_LOG;
   localparam int MCW   = $clog2(ND + 1);
   localparam int QW    = 2 * rlm_pkg::LEVEL_W * 2;
   localparam int DCW   = $clog2(QW);
   localparam int SQW   = 2 * rlm_pkg::LEVEL_W;

   typedef enum logic [2:0] {
      IDLE,
      MUL,
      LOAD,
      DIV,
      ROOT_SQ,
      ROOT_CMP,
      EMIT
   } state_type;

   state_type                    state_ff;
   logic [PW-1:0]                sum_sh_ff;
   logic [CW-1:0]                count_ff;
   logic [PPW-1:0]               pp_ff;
   logic [RW-1:0]                prod_ff;
   logic [MCW-1:0]               mcnt_ff;
   logic [NW-1:0]                rem_ff;
   logic [NW-1:0]                dv_ff;
   logic [QW-1:0]                quot_ff;
   logic [DCW-1:0]               dcnt_ff;
   logic [rlm_pkg::LEVEL_W-1:0]  lvl_ff;
   logic [rlm_pkg::LEVEL_W-1:0]  probe_ff;
   logic [SQW-1:0]               sq_ff;
   logic                         rsp_valid_ff;
   logic [rlm_pkg::LEVEL_W-1:0]  rsp_level_ff;

   logic [DIG_W-1:0]             digit;
   logic [PPW-1:0]               pp_prod;
   logic [RW-1:0]                prod_sum;
   logic                         div_fits;
   logic [NW-1:0]                rem_diff;
   logic [rlm_pkg::LEVEL_W-1:0]  trial;
   logic [SQW-1:0]               sq_prod;
   logic [QW-1:0]                quad;
   logic                         root_fits;

   // Multiply: one 24-bit digit of the sum per cycle, most significant first.
   assign digit    = sum_sh_ff[PW-1 -: DIG_W];
   assign pp_prod  = PPW'(digit) * PPW'(FULL_SCALE_SQ);
   assign prod_sum = (prod_ff << DIG_W) + RW'(pp_ff);

   // Divide: one quotient bit per cycle.
   assign div_fits = (rem_ff >= dv_ff);
   assign rem_diff = rem_ff - dv_ff;

   // Root search: one level bit per ROOT_SQ and ROOT_CMP pair, square then square again.
   assign trial     = lvl_ff | probe_ff;
   assign sq_prod   = SQW'(trial) * SQW'(trial);
   assign quad      = QW'(sq_ff) * QW'(sq_ff);
   assign root_fits = (quad <= quot_ff);

   assign q_pop     = (state_ff == IDLE) && !q_status.empty;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_level = rsp_level_ff;

   // Sequencer with the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && state_ff != EMIT) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            IDLE: begin
               if (!q_status.empty) begin
                  sum_sh_ff <= PW'(q_data[SW+CW-1:CW]);
                  count_ff  <= q_data[CW-1:0];
                  mcnt_ff   <= '0;
                  prod_ff   <= '0;
                  state_ff  <= MUL;
               end
            end
            MUL: begin
               pp_ff     <= pp_prod;
               sum_sh_ff <= sum_sh_ff << DIG_W;
               mcnt_ff   <= mcnt_ff + MCW'(1);
               if (mcnt_ff != '0) begin
                  prod_ff <= prod_sum;
               end
               if (mcnt_ff == MCW'(ND)) begin
                  state_ff <= LOAD;
               end
            end
            LOAD: begin
               rem_ff   <= prod_ff[RW-1:rlm_pkg::SQ_LOG];
               dv_ff    <= NW'(count_ff) << (QW - 1);
               dcnt_ff  <= '0;
               state_ff <= DIV;
            end
            DIV: begin
               if (div_fits) begin
                  rem_ff <= rem_diff;
               end
               quot_ff <= {quot_ff[QW-2:0], div_fits};
               dv_ff   <= dv_ff >> 1;
               dcnt_ff <= dcnt_ff + DCW'(1);
               if (dcnt_ff == DCW'(QW - 1)) begin
                  lvl_ff   <= '0;
                  probe_ff <= rlm_pkg::LEVEL_W'(1) << (rlm_pkg::LEVEL_W - 1);
                  state_ff <= ROOT_SQ;
               end
            end
            ROOT_SQ: begin
               sq_ff    <= sq_prod;
               state_ff <= ROOT_CMP;
            end
            ROOT_CMP: begin
               if (root_fits) begin
                  lvl_ff <= trial;
               end
               probe_ff <= probe_ff >> 1;
               state_ff <= probe_ff[0] ? EMIT : ROOT_SQ;
            end
            EMIT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_level_ff <= lvl_ff;
                  state_ff     <= IDLE;
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   // The quotient never exceeds full scale, so the level saturates at 255.
   a_quot_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == EMIT) |-> (quot_ff <= QW'(FULL_SCALE_SQ)))
      else $error("quotient above full scale");

   // The divide leaves a remainder below the sample count.
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == EMIT) |-> (rem_ff < NW'(count_ff)))
      else $error("divide remainder not below divisor");

   // A new result word only comes out of the emit step.
   a_emit_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == EMIT))
      else $error("result word raised outside the emit step");

endmodule

`default_nettype wire
